// ----- rtl/core/mlpd_pkg.sv -----
// ---------------------------------------------------------------------------
// mlpd_pkg: shared types and constants for the marker/length/payload deframer
// Marker texts, mode codes, parser phase encoding and the result record.
// ---------------------------------------------------------------------------
package mlpd_pkg;

    localparam int unsigned BYTES_RX_WIDTH = 31;
    localparam int unsigned LEN_MARK_LEN   = 12;
    localparam int unsigned DATA_MARK_LEN  = 10;

    // receive_mode codes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_KEY = 2'd1;
    localparam logic [1:0] MODE_MSG = 2'd2;

    // length field position within the four length bytes
    localparam logic [1:0] LEN_BYTE_0 = 2'd0;
    localparam logic [1:0] LEN_BYTE_1 = 2'd1;
    localparam logic [1:0] LEN_BYTE_2 = 2'd2;
    localparam logic [1:0] LEN_BYTE_3 = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_HUNT_LEN  = 5'b00010,
        PH_LEN       = 5'b00100,
        PH_HUNT_DATA = 5'b01000,
        PH_PAYLOAD   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]                payload_byte;
        logic                      payload_valid;
        logic                      frame_done;
        logic                      frame_kind;
        logic [BYTES_RX_WIDTH-1:0] bytes_received;
    } result_t;

    localparam logic [7:0] LEN_MARK_KEY [0:11] = '{
        8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h4F, 8'h66, 8'h4B, 8'h65, 8'h79, 8'h3A
    };
    localparam logic [7:0] LEN_MARK_MSG [0:11] = '{
        8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h4F, 8'h66, 8'h4D, 8'h73, 8'h67, 8'h3A
    };
    localparam logic [7:0] DATA_MARK_KEY [0:9] = '{
        8'h64, 8'h61, 8'h74, 8'h61, 8'h4F, 8'h66, 8'h4B, 8'h65, 8'h79, 8'h3A
    };
    localparam logic [7:0] DATA_MARK_MSG [0:9] = '{
        8'h64, 8'h61, 8'h74, 8'h61, 8'h4F, 8'h66, 8'h4D, 8'h73, 8'h67, 8'h3A
    };

    // character at a marker position; positions past the end read as zero
    function automatic logic [7:0] marker_char(
        input logic       is_data,
        input logic       is_msg,
        input logic [3:0] pos
    );
        logic [7:0] c;
        c = 8'h00;
        if (is_data) begin
            if (pos < 4'(DATA_MARK_LEN)) begin
                c = is_msg ? DATA_MARK_MSG[pos] : DATA_MARK_KEY[pos];
            end
        end
        else begin
            if (pos < 4'(LEN_MARK_LEN)) begin
                c = is_msg ? LEN_MARK_MSG[pos] : LEN_MARK_KEY[pos];
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/mlpd_in_reg.sv -----
// ---------------------------------------------------------------------------
// mlpd_in_reg: input register
// Holds one received byte until the parser consumes it.
// ---------------------------------------------------------------------------
module mlpd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ----- rtl/core/mlpd_parser.sv -----
// ---------------------------------------------------------------------------
// mlpd_parser: frame parser
// Marker matching, length capture and payload counting, one byte per step.
// ---------------------------------------------------------------------------
module mlpd_parser #(
    parameter int unsigned LEN_BITS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  logic                step,
    input  logic [7:0]          cur_byte,
    output logic                has_result,
    output mlpd_pkg::result_t   result
);

    localparam logic [30:0] LEN_MAX = 31'((64'd1 << LEN_BITS) - 64'd1);

    mlpd_pkg::phase_t    phase_reg, phase_next;
    logic [1:0]          mode_reg, mode_next;
    logic [3:0]          pos_reg, pos_next;
    logic [1:0]          lbc_reg, lbc_next;
    logic [23:0]         len_lo_reg, len_lo_next;
    logic [LEN_BITS-1:0] flen_reg, flen_next;
    logic [LEN_BITS-1:0] count_reg, count_next;

    logic                armed;
    logic                is_msg;
    logic                is_data;
    logic [3:0]          mark_len;
    logic [3:0]          pos_cur;
    logic                hit;
    logic                first_hit;
    logic                mark_done;
    logic [3:0]          pos_match;
    logic [30:0]         len_full;
    logic [LEN_BITS-1:0] count_inc;

    assign armed   = (mode_reg == mlpd_pkg::MODE_KEY) || (mode_reg == mlpd_pkg::MODE_MSG);
    assign is_msg  = (mode_reg == mlpd_pkg::MODE_MSG);
    assign is_data = (phase_reg == mlpd_pkg::PH_HUNT_DATA);

    // marker matcher, markers have no self-overlap
    always_comb
    begin
        mark_len  = is_data ? 4'(mlpd_pkg::DATA_MARK_LEN) : 4'(mlpd_pkg::LEN_MARK_LEN);
        pos_cur   = (pos_reg >= mark_len) ? 4'd0 : pos_reg;
        hit       = (cur_byte == mlpd_pkg::marker_char(is_data, is_msg, pos_cur));
        first_hit = (cur_byte == mlpd_pkg::marker_char(is_data, is_msg, 4'd0));
        mark_done = hit && ((pos_cur + 4'd1) == mark_len);
        if (hit)
        begin
            pos_match = mark_done ? 4'd0 : pos_cur + 4'd1;
        end
        else
        begin
            pos_match = first_hit ? 4'd1 : 4'd0;
        end
    end

    assign len_full  = {cur_byte[6:0], len_lo_reg};
    assign count_inc = count_reg + LEN_BITS'(1);

    // outcome for the held byte, committed only when it steps
    always_comb
    begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        lbc_next    = lbc_reg;
        len_lo_next = len_lo_reg;
        flen_next   = flen_reg;
        count_next  = count_reg;
        has_result  = 1'b0;
        result      = '0;
        result.frame_kind = is_msg;

        if (cfg_we)
        begin
            mode_next   = cfg_wdata;
            phase_next  = ((cfg_wdata == mlpd_pkg::MODE_KEY) ||
                           (cfg_wdata == mlpd_pkg::MODE_MSG)) ?
                          mlpd_pkg::PH_HUNT_LEN : mlpd_pkg::PH_IDLE;
            pos_next    = '0;
            lbc_next    = '0;
            len_lo_next = '0;
            flen_next   = '0;
            count_next  = '0;
        end
        else
        begin
            if (!armed)
            begin
                phase_next = mlpd_pkg::PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    mlpd_pkg::PH_IDLE:
                    begin
                        phase_next = mlpd_pkg::PH_IDLE;
                    end
                    mlpd_pkg::PH_HUNT_LEN:
                    begin
                        pos_next = pos_match;
                        if (mark_done)
                        begin
                            phase_next  = mlpd_pkg::PH_LEN;
                            lbc_next    = '0;
                            len_lo_next = '0;
                            flen_next   = '0;
                        end
                    end
                    mlpd_pkg::PH_LEN:
                    begin
                        unique case (lbc_reg)
                            mlpd_pkg::LEN_BYTE_0: len_lo_next[7:0]   = cur_byte;
                            mlpd_pkg::LEN_BYTE_1: len_lo_next[15:8]  = cur_byte;
                            mlpd_pkg::LEN_BYTE_2: len_lo_next[23:16] = cur_byte;
                            mlpd_pkg::LEN_BYTE_3:
                            begin
                                // negative length counts as zero, large ones saturate
                                if (cur_byte[7])
                                begin
                                    flen_next = '0;
                                end
                                else if (len_full > LEN_MAX)
                                begin
                                    flen_next = LEN_MAX[LEN_BITS-1:0];
                                end
                                else
                                begin
                                    flen_next = len_full[LEN_BITS-1:0];
                                end
                                pos_next   = '0;
                                phase_next = mlpd_pkg::PH_HUNT_DATA;
                            end
                            default: ;
                        endcase
                        lbc_next = lbc_reg + 2'd1;
                    end
                    mlpd_pkg::PH_HUNT_DATA:
                    begin
                        pos_next = pos_match;
                        if (mark_done)
                        begin
                            count_next = '0;
                            if (flen_reg == '0)
                            begin
                                // empty frame completes on the marker itself
                                phase_next        = mlpd_pkg::PH_IDLE;
                                has_result        = 1'b1;
                                result.frame_done = 1'b1;
                            end
                            else
                            begin
                                phase_next = mlpd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    mlpd_pkg::PH_PAYLOAD:
                    begin
                        count_next            = count_inc;
                        has_result            = 1'b1;
                        result.payload_byte   = cur_byte;
                        result.payload_valid  = 1'b1;
                        result.bytes_received = mlpd_pkg::BYTES_RX_WIDTH'(count_inc);
                        if (count_inc >= flen_reg)
                        begin
                            result.frame_done = 1'b1;
                            phase_next        = mlpd_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = mlpd_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mlpd_pkg::PH_IDLE;
            mode_reg   <= mlpd_pkg::MODE_OFF;
            pos_reg    <= '0;
            lbc_reg    <= '0;
            len_lo_reg <= '0;
            flen_reg   <= '0;
            count_reg  <= '0;
        end
        else if (cfg_we || step)
        begin
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            lbc_reg    <= lbc_next;
            len_lo_reg <= len_lo_next;
            flen_reg   <= flen_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mlpd_pkg::PH_PAYLOAD) |-> (count_reg < flen_reg))
        else $error("payload count reached frame length while still in payload");

    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step && has_result) |->
            ((phase_reg == mlpd_pkg::PH_HUNT_DATA) || (phase_reg == mlpd_pkg::PH_PAYLOAD)))
        else $error("result produced outside data marker hunt or payload");

    a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !cfg_we && has_result && result.frame_done) |=>
            (phase_reg == mlpd_pkg::PH_IDLE))
        else $error("parser still armed after frame done");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < 4'(mlpd_pkg::LEN_MARK_LEN))
        else $error("marker match position out of range");
`endif

endmodule

// ----- rtl/core/mlpd_out_reg.sv -----
// ---------------------------------------------------------------------------
// mlpd_out_reg: result register
// Holds one result item until the downstream side takes it.
// ---------------------------------------------------------------------------
module mlpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mlpd_pkg::result_t load_data,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output mlpd_pkg::result_t held
);

    logic              valid_reg;
    logic              valid_next;
    mlpd_pkg::result_t data_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |-> !load)
        else $error("result register loaded while holding a stalled item");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");

    a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_stall && !load) |=> !valid_reg)
        else $error("taken result still shown");
`endif

endmodule

// ----- rtl/core/marker_length_payload_deframer_top.sv -----
// ---------------------------------------------------------------------------
// marker_length_payload_deframer_top: marker/length/payload deframer
// Finds the length marker, captures a little-endian length, finds the data
// marker and passes that many payload bytes on, flagging the last one.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | rx_byte
//  out      | out_valid / out_stall | payload_byte, payload_valid, frame_done,
//           |                       | frame_kind, bytes_received
//  cfg      | cfg_we                | cfg_wdata (receive_mode)
//
//  one byte per cycle sustained while no result is held back by out_stall;
//  a byte is held in the input register, and its result is loaded into the result
//  register as the byte advances, which is when out_valid rises
//  reset: parser idle with receive_mode off, both registers empty
//  bytes that give no result pass even while a result waits at the output;
//  a byte that gives a result waits in the input register for a free slot
// ---------------------------------------------------------------------------
module marker_length_payload_deframer_top #(
    parameter int unsigned LEN_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic        frame_done,
    output logic        frame_kind,
    output logic [30:0] bytes_received
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              advance;
    logic              has_result;
    logic              out_free;
    mlpd_pkg::result_t result;
    mlpd_pkg::result_t out_item;

    // an item leaves the input register unless its result has nowhere to go
    assign advance = held_valid && (!has_result || out_free);

    mlpd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    mlpd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .step       (advance),
        .cur_byte   (held_byte),
        .has_result (has_result),
        .result     (result)
    );

    mlpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .load_data (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .held      (out_item)
    );

    assign payload_byte   = out_item.payload_byte;
    assign payload_valid  = out_item.payload_valid;
    assign frame_done     = out_item.frame_done;
    assign frame_kind     = out_item.frame_kind;
    assign bytes_received = out_item.bytes_received;

endmodule
